### design/ppfc_pkg.sv
// ----------------------------------------------------------------------------
// ppfc_pkg
// Shared types and codes for the palette pixel format converter.
// ----------------------------------------------------------------------------
package ppfc_pkg;

    localparam int PIXEL_W  = 32;
    localparam int COLOR_W  = 24;
    localparam int INDEX_W  = 8;
    localparam int FORMAT_W = 3;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

    // input depth codes
    typedef enum logic [FORMAT_W-1:0] {
        IN_1BPP  = 3'd0,
        IN_8BPP  = 3'd1,
        IN_15BPP = 3'd2,
        IN_16BPP = 3'd3,
        IN_24BPP = 3'd4,
        IN_32BPP = 3'd5
    } in_fmt_t;

    // output depth codes
    typedef enum logic [FORMAT_W-1:0] {
        OUT_1BPP  = 3'd0,
        OUT_15BPP = 3'd1,
        OUT_16BPP = 3'd2,
        OUT_24BPP = 3'd3,
        OUT_32BPP = 3'd4
    } out_fmt_t;

    // item actions
    typedef enum logic {
        ACT_CONVERT   = 1'b0,
        ACT_PAL_WRITE = 1'b1
    } action_t;

    // configuration register indexes
    localparam logic CFG_IN_FORMAT  = 1'b0;
    localparam logic CFG_OUT_FORMAT = 1'b1;

endpackage

### design/ppfc_if.sv
// ----------------------------------------------------------------------------
// ppfc_if
// Valid/ready channels of the converter: item input and pixel output.
// ----------------------------------------------------------------------------
interface ppfc_in_if
    import ppfc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 action;
    logic [PIXEL_W-1:0]   pixel_in;
    logic [INDEX_W-1:0]   palette_index;
    logic [COLOR_W-1:0]   palette_color;

    modport source (output valid, action, pixel_in, palette_index, palette_color,
                    input ready);
    modport sink   (input valid, action, pixel_in, palette_index, palette_color,
                    output ready);
endinterface

interface ppfc_out_if
    import ppfc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [PIXEL_W-1:0]   pixel_out;

    modport source (output valid, pixel_out, input ready);
    modport sink   (input valid, pixel_out, output ready);
endinterface

### design/palette_pixel_format_converter_unit.sv
// ----------------------------------------------------------------------------
// palette_pixel_format_converter_unit
// Converts one pixel per beat between depths, with a 256-entry palette.
// ----------------------------------------------------------------------------
//
//  port   | dir | beat carries
//  -------+-----+---------------------------------------------------------
//  src    | in  | action, pixel_in, palette_index, palette_color
//  dst    | out | pixel_out (one beat per convert item, none per palette write)
//  cfg_*  | in  | in_format (index 0), out_format (index 1)
//
//  One item per cycle sustained while dst does not stall. A convert beat
//  passes stage 1, beside the palette memory read, then the output register
//  before it reaches dst. Palette writes land at acceptance, so a convert
//  accepted in the next cycle already reads the new entry.
//  Reset clears the formats to 32 bpp in and out and the entry valid bits;
//  an entry never written reads as black. No clearing pass is needed.
//  A dst stall backs up into the stage after the memory, then into src.ready.
//
module palette_pixel_format_converter_unit
    import ppfc_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256
)(
    input  logic                clk,
    input  logic                rst_n,
    ppfc_in_if.sink             src,
    ppfc_out_if.source          dst,
    input  logic                cfg_we,
    input  logic                cfg_addr,
    input  logic [FORMAT_W-1:0] cfg_data
);

    localparam int IDX_W = $clog2(PALETTE_ENTRIES);

    // configuration
    logic [FORMAT_W-1:0] in_fmt_reg;
    logic [FORMAT_W-1:0] out_fmt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_fmt_reg  <= IN_32BPP;
            out_fmt_reg <= OUT_32BPP;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_IN_FORMAT:  in_fmt_reg  <= cfg_data;
                CFG_OUT_FORMAT: out_fmt_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // handshake
    logic s1_valid_reg;
    logic out_valid_reg;
    logic out_free;
    logic s1_advance;
    logic accept;
    logic conv_accept;
    logic wr_en;

    assign out_free    = !out_valid_reg || dst.ready;
    assign s1_advance  = s1_valid_reg && out_free;
    assign src.ready   = !s1_valid_reg || out_free;
    assign accept      = src.valid && src.ready;
    assign conv_accept = accept && (src.action == ACT_CONVERT);

    // palette memory and per-entry valid bits
    logic [COLOR_W-1:0]         pal_mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] entry_valid_reg;
    logic [IDX_W-1:0]           wr_addr;
    logic [IDX_W-1:0]           rd_addr;
    logic                       wr_in_range;
    logic                       rd_in_range;
    logic [COLOR_W-1:0]         rd_data_reg;
    logic                       rd_hit_reg;

    assign wr_addr     = src.palette_index[IDX_W-1:0];
    assign rd_addr     = src.pixel_in[IDX_W-1:0];
    assign wr_in_range = {1'b0, src.palette_index} < 9'(PALETTE_ENTRIES);
    assign rd_in_range = {1'b0, src.pixel_in[INDEX_W-1:0]} < 9'(PALETTE_ENTRIES);
    assign wr_en       = accept && (src.action == ACT_PAL_WRITE) && wr_in_range;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pal_mem[wr_addr] <= src.palette_color;
        end
        if (conv_accept)
        begin
            rd_data_reg <= pal_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            rd_hit_reg      <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                entry_valid_reg[wr_addr] <= 1'b1;
            end
            if (conv_accept)
            begin
                rd_hit_reg <= rd_in_range && entry_valid_reg[rd_addr];
            end
        end
    end

    // stage 1: pixel waits beside the memory read
    logic [PIXEL_W-1:0] s1_pixel_reg;
    logic               s1_valid_next;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
        if (conv_accept)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (conv_accept)
        begin
            s1_pixel_reg <= src.pixel_in;
        end
    end

    // unpack to components, then pack to the output depth
    logic [COLOR_W-1:0] pal_color;
    logic [7:0]         r, g, b, a;
    logic [PIXEL_W-1:0] pixel_next;

    assign pal_color = rd_hit_reg ? rd_data_reg : '0;

    always_comb
    begin
        a = ALPHA_OPAQUE;
        r = '0;
        g = '0;
        b = '0;
        case (in_fmt_reg)
            IN_1BPP:
            begin
                if (s1_pixel_reg != '0)
                begin
                    r = 8'hff;
                    g = 8'hff;
                    b = 8'hff;
                end
            end
            IN_8BPP:
            begin
                r = pal_color[23:16];
                g = pal_color[15:8];
                b = pal_color[7:0];
            end
            IN_15BPP:
            begin
                r = {s1_pixel_reg[14:10], s1_pixel_reg[14:12]};
                g = {s1_pixel_reg[9:5],   s1_pixel_reg[9:7]};
                b = {s1_pixel_reg[4:0],   s1_pixel_reg[4:2]};
            end
            IN_16BPP:
            begin
                r = {s1_pixel_reg[15:11], s1_pixel_reg[15:13]};
                g = {s1_pixel_reg[10:5],  s1_pixel_reg[10:9]};
                b = {s1_pixel_reg[4:0],   s1_pixel_reg[4:2]};
            end
            IN_24BPP:
            begin
                r = s1_pixel_reg[7:0];
                g = s1_pixel_reg[15:8];
                b = s1_pixel_reg[23:16];
            end
            IN_32BPP:
            begin
                r = s1_pixel_reg[7:0];
                g = s1_pixel_reg[15:8];
                b = s1_pixel_reg[23:16];
                a = s1_pixel_reg[31:24];
            end
            default: ;
        endcase

        case (out_fmt_reg)
            OUT_1BPP:  pixel_next = {31'b0, ((r | g | b) != 8'h00)};
            OUT_15BPP: pixel_next = {17'b0, r[7:3], g[7:3], b[7:3]};
            OUT_16BPP: pixel_next = {16'b0, r[7:3], g[7:2], b[7:3]};
            OUT_24BPP: pixel_next = {8'b0, r, g, b};
            OUT_32BPP: pixel_next = {a, r, g, b};
            default:   pixel_next = '0;
        endcase
    end

    // output register
    logic [PIXEL_W-1:0] pixel_out_reg;
    logic               out_valid_next;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (dst.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (s1_advance)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            pixel_out_reg <= pixel_next;
        end
    end

    assign dst.valid     = out_valid_reg;
    assign dst.pixel_out = pixel_out_reg;

    // checks
    a_wr_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> entry_valid_reg[$past(wr_addr)])
        else $error("palette write did not mark its entry valid");

    a_conv_enters_s1: assert property (@(posedge clk) disable iff (!rst_n)
        conv_accept |=> s1_valid_reg)
        else $error("accepted convert item lost before stage 1");

    a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("output beat without an item in stage 1");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !src.ready |-> (s1_valid_reg && out_valid_reg && !dst.ready))
        else $error("input stalled while the pipeline has room");

endmodule

### tb/ppfc_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ppfc_tb_pkg
// Pixel scoreboard for the converter bench: keeps its own copy of the palette
// and the formats, predicts every converted pixel and checks the dst beats.
// ----------------------------------------------------------------------------
package ppfc_tb_pkg;

    import ppfc_pkg::*;

    localparam int REPORT_LIMIT = 10;
    localparam int PALETTE_SIZE = 1 << INDEX_W;

    class pixel_scoreboard;

        logic [COLOR_W-1:0]  palette [PALETTE_SIZE];
        logic [FORMAT_W-1:0] in_fmt;
        logic [FORMAT_W-1:0] out_fmt;
        logic [PIXEL_W-1:0]  pending_pixels [$];
        int                  mismatches;

        function new();
            foreach (palette[i])
            begin
                palette[i] = '0;
            end
            in_fmt     = IN_32BPP;
            out_fmt    = OUT_32BPP;
            mismatches = 0;
        endfunction

        function void set_format(logic addr, logic [FORMAT_W-1:0] data);
            if (addr == CFG_IN_FORMAT)
            begin
                in_fmt = data;
            end
            else
            begin
                out_fmt = data;
            end
        endfunction

        // unpack to 8-bit components, then repack in the output depth
        function logic [PIXEL_W-1:0] predict_pixel(logic [PIXEL_W-1:0] p);
            logic [7:0]         a;
            logic [7:0]         r;
            logic [7:0]         g;
            logic [7:0]         b;
            logic [COLOR_W-1:0] c;
            a = ALPHA_OPAQUE;
            r = '0;
            g = '0;
            b = '0;
            case (in_fmt)
                IN_1BPP:
                begin
                    if (p != '0)
                    begin
                        r = '1;
                        g = '1;
                        b = '1;
                    end
                end
                IN_8BPP:
                begin
                    c = palette[p[7:0]];
                    r = c[23:16];
                    g = c[15:8];
                    b = c[7:0];
                end
                IN_15BPP:
                begin
                    r = {p[14:10], p[14:12]};
                    g = {p[9:5], p[9:7]};
                    b = {p[4:0], p[4:2]};
                end
                IN_16BPP:
                begin
                    r = {p[15:11], p[15:13]};
                    g = {p[10:5], p[10:9]};
                    b = {p[4:0], p[4:2]};
                end
                IN_24BPP:
                begin
                    r = p[7:0];
                    g = p[15:8];
                    b = p[23:16];
                end
                IN_32BPP:
                begin
                    r = p[7:0];
                    g = p[15:8];
                    b = p[23:16];
                    a = p[31:24];
                end
                default:
                begin
                    // unused input codes decode to opaque black
                end
            endcase
            case (out_fmt)
                OUT_1BPP:  return {31'b0, |{r, g, b}};
                OUT_15BPP: return {17'b0, r[7:3], g[7:3], b[7:3]};
                OUT_16BPP: return {16'b0, r[7:3], g[7:2], b[7:3]};
                OUT_24BPP: return {8'b0, r, g, b};
                OUT_32BPP: return {a, r, g, b};
                default:   return '0;
            endcase
        endfunction

        function void note_item(logic act, logic [PIXEL_W-1:0] pix,
                                logic [INDEX_W-1:0] idx, logic [COLOR_W-1:0] col);
            if (act == ACT_PAL_WRITE)
            begin
                palette[idx] = col;
            end
            else
            begin
                pending_pixels.push_back(predict_pixel(pix));
            end
        endfunction

        function void check_pixel(logic [PIXEL_W-1:0] actual);
            logic [PIXEL_W-1:0] expected;
            if (pending_pixels.size() == 0)
            begin
                if (mismatches < REPORT_LIMIT)
                begin
                    $display("unexpected pixel beat: got %08h", actual);
                end
                mismatches++;
            end
            else
            begin
                expected = pending_pixels.pop_front();
                if (actual !== expected)
                begin
                    if (mismatches < REPORT_LIMIT)
                    begin
                        $display("pixel mismatch: expected %08h, got %08h (in %0d, out %0d)",
                                 expected, actual, in_fmt, out_fmt);
                    end
                    mismatches++;
                end
            end
        endfunction

    endclass

endpackage

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives convert and palette beats through every pair of format codes, with
// bursty input and a stalling output, and checks each pixel against the
// scoreboard's prediction.
// ----------------------------------------------------------------------------
module testbench;

    import ppfc_pkg::*;
    import ppfc_tb_pkg::*;

    localparam int WATCHDOG_LIMIT    = 2000;
    localparam int SETTLE_CYCLES     = 4;
    localparam int ITEMS_PER_SETTING = 17;
    localparam int FORMAT_CODES      = 1 << FORMAT_W;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic                cfg_addr;
    logic [FORMAT_W-1:0] cfg_data;

    int burst_left;
    int max_gap;
    int stall_pct;
    int stall_left;
    int idle_cycles;

    pixel_scoreboard pixel_sb;

    ppfc_in_if  src_if ();
    ppfc_out_if dst_if ();

    palette_pixel_format_converter_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .src      (src_if),
        .dst      (dst_if),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // output stalls: random runs of low ready, rate set per phase
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dst_if.ready <= 1'b0;
            stall_left   <= 0;
        end
        else if (stall_left > 0)
        begin
            dst_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else if ($urandom_range(0, 99) < stall_pct)
        begin
            dst_if.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 7);
        end
        else
        begin
            dst_if.ready <= 1'b1;
        end
    end

    // beat monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (src_if.valid && src_if.ready)
            begin
                pixel_sb.note_item(src_if.action, src_if.pixel_in,
                                   src_if.palette_index, src_if.palette_color);
            end
            if (dst_if.valid && dst_if.ready)
            begin
                pixel_sb.check_pixel(dst_if.pixel_out);
            end
            if ((src_if.valid && src_if.ready) || (dst_if.valid && dst_if.ready) || cfg_we)
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("CHECK FAILED");
                    $finish;
                end
            end
        end
    end

    task automatic send_item(action_t act, logic [PIXEL_W-1:0] pix,
                             logic [INDEX_W-1:0] idx, logic [COLOR_W-1:0] col,
                             bit last);
        src_if.valid         <= 1'b1;
        src_if.action        <= act;
        src_if.pixel_in      <= pix;
        src_if.palette_index <= idx;
        src_if.palette_color <= col;
        do
            @(posedge clk);
        while (!src_if.ready);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        // drop valid between bursts when gaps are on; always drop it at the end of a phase
        if (last || (burst_left == 0 && max_gap > 0))
        begin
            src_if.valid <= 1'b0;
            repeat ($urandom_range(1, (max_gap > 0) ? max_gap : 1)) @(posedge clk);
        end
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
        end
    endtask

    task automatic send_random(bit last);
        action_t            act;
        logic [PIXEL_W-1:0] pix;
        logic [INDEX_W-1:0] idx;
        logic [COLOR_W-1:0] col;
        act = ($urandom_range(0, 3) == 0) ? ACT_PAL_WRITE : ACT_CONVERT;
        case ($urandom_range(0, 7))
            0:       pix = '0;
            1:       pix = '1;
            2:       pix = PIXEL_W'($urandom_range(0, 255));
            3:       pix = PIXEL_W'(1) << $urandom_range(0, PIXEL_W - 1);
            // junk above a low palette index
            4:       pix = ($urandom() & 32'hffff_ff00) | PIXEL_W'($urandom_range(0, 15));
            default: pix = $urandom();
        endcase
        // keep half the writes on entries 0 to 15 so the low-index reads hit them
        idx = ($urandom_range(0, 1) == 1) ? INDEX_W'($urandom_range(0, 15))
                                          : INDEX_W'($urandom_range(0, 255));
        case ($urandom_range(0, 5))
            0:       col = '0;
            1:       col = '1;
            default: col = COLOR_W'($urandom());
        endcase
        send_item(act, pix, idx, col, last);
    endtask

    task automatic drain();
        @(posedge clk);
        while (pixel_sb.pending_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_formats(logic [FORMAT_W-1:0] in_code, logic [FORMAT_W-1:0] out_code);
        drain();
        cfg_we   <= 1'b1;
        cfg_addr <= CFG_IN_FORMAT;
        cfg_data <= in_code;
        @(posedge clk);
        pixel_sb.set_format(CFG_IN_FORMAT, in_code);
        cfg_addr <= CFG_OUT_FORMAT;
        cfg_data <= out_code;
        @(posedge clk);
        pixel_sb.set_format(CFG_OUT_FORMAT, out_code);
        cfg_we   <= 1'b0;
    endtask

    initial
    begin
        int phase;
        pixel_sb    = new();
        idle_cycles = 0;
        burst_left  = 8;
        max_gap     = 2;
        stall_pct   = 20;

        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_addr             <= CFG_IN_FORMAT;
        cfg_data             <= '0;
        src_if.valid         <= 1'b0;
        src_if.action        <= ACT_CONVERT;
        src_if.pixel_in      <= '0;
        src_if.palette_index <= '0;
        src_if.palette_color <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset formats: 32 bpp in and out
        send_item(ACT_CONVERT, 32'h0000_0000, '0, '0, 1'b0);
        send_item(ACT_CONVERT, 32'hffff_ffff, '0, '0, 1'b0);
        send_item(ACT_CONVERT, 32'h80c0_e0f1, '0, '0, 1'b1);

        // palette: extreme entries, an unwritten entry, overwrite then read back
        write_formats(IN_8BPP, OUT_24BPP);
        send_item(ACT_PAL_WRITE, $urandom(), 8'd0, 24'hff_ffff, 1'b0);
        send_item(ACT_PAL_WRITE, $urandom(), 8'd255, 24'ha5_c3e1, 1'b0);
        send_item(ACT_CONVERT, 32'hffff_ff00, '0, '0, 1'b0);
        send_item(ACT_CONVERT, 32'h0000_00ff, '0, '0, 1'b0);
        send_item(ACT_CONVERT, 32'h0000_0002, '0, '0, 1'b0);
        send_item(ACT_PAL_WRITE, '0, 8'd0, 24'h00_0000, 1'b0);
        send_item(ACT_CONVERT, 32'h0000_0000, '0, '0, 1'b1);

        write_formats(IN_15BPP, OUT_16BPP);
        send_item(ACT_CONVERT, 32'h0000_7fff, '0, '0, 1'b0);
        send_item(ACT_CONVERT, 32'hffff_8000, '0, '0, 1'b0);
        send_item(ACT_CONVERT, 32'h0000_4210, '0, '0, 1'b1);

        write_formats(IN_16BPP, OUT_15BPP);
        send_item(ACT_CONVERT, 32'h0000_ffff, '0, '0, 1'b0);
        send_item(ACT_CONVERT, 32'hffff_0000, '0, '0, 1'b0);
        send_item(ACT_CONVERT, 32'h0000_8410, '0, '0, 1'b1);

        // 1 bpp input: only the top bit or only the bottom bit set is still white
        write_formats(IN_1BPP, OUT_1BPP);
        send_item(ACT_CONVERT, 32'h0000_0000, '0, '0, 1'b0);
        send_item(ACT_CONVERT, 32'h8000_0000, '0, '0, 1'b0);
        send_item(ACT_CONVERT, 32'h0000_0001, '0, '0, 1'b1);

        write_formats(IN_24BPP, OUT_32BPP);
        send_item(ACT_CONVERT, 32'hff00_0000, '0, '0, 1'b0);
        send_item(ACT_CONVERT, 32'h00ff_fffe, '0, '0, 1'b1);

        // sweep every pair of format codes, unused ones included
        for (int in_code = 0; in_code < FORMAT_CODES; in_code++)
        begin
            for (int out_code = 0; out_code < FORMAT_CODES; out_code++)
            begin
                phase     = in_code * FORMAT_CODES + out_code;
                max_gap   = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 3 : 10);
                stall_pct = (phase % 4 == 0) ? 0 : ((phase % 4 == 1) ? 10
                          : ((phase % 4 == 2) ? 40 : 70));
                write_formats(FORMAT_W'(in_code), FORMAT_W'(out_code));
                repeat (ITEMS_PER_SETTING - 1) send_random(1'b0);
                send_random(1'b1);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pixel_sb.mismatches == 0 && pixel_sb.pending_pixels.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### sim.f
design/ppfc_pkg.sv
design/ppfc_if.sv
design/palette_pixel_format_converter_unit.sv
tb/ppfc_tb_pkg.sv
tb/testbench.sv
